// ----- hdl/mfbr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfbr_pkg
// Shared types, constants and helpers of the mono framebuffer band reformatter.
// ----------------------------------------------------------------------------
package mfbr_pkg;

   localparam int STORE_BYTES   = 4224;
   localparam int MAX_ROW_BYTES = 32;
   localparam int ROWS_PER_BAND = 12;
   localparam int MEM_W  = $clog2(STORE_BYTES);
   localparam int ADDR_W = $clog2(256 * MAX_ROW_BYTES + 128);

   localparam logic [2:0] KIND_PIXEL  = 3'd0;
   localparam logic [2:0] KIND_REGION = 3'd1;
   localparam logic [2:0] KIND_DATA   = 3'd2;
   localparam logic [2:0] KIND_FLUSH  = 3'd3;
   localparam logic [2:0] KIND_CLEAR  = 3'd4;

   localparam logic [7:0] CSR_ROW_BYTES  = 8'd0;
   localparam logic [7:0] CSR_BAND_COUNT = 8'd1;

   localparam logic [5:0] ROW_BYTES_RESET  = 6'd32;
   localparam logic [3:0] BAND_COUNT_RESET = 4'd11;

   typedef enum logic [2:0] {
      OP_PIXEL,
      OP_REGION,
      OP_DATA,
      OP_FLUSH,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  pixel_x;
      logic [7:0]  row;
      logic        pixel_on;
      logic [4:0]  start_byte;
      logic [8:0]  region_width_px;
      logic [7:0]  region_height;
      logic [12:0] byte_limit;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       group_last;
      logic       frame_last;
   } rsp_type;

   typedef struct packed {
      op_type  op;
      req_type req;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_out_type;

   typedef struct packed {
      logic pop;
      logic idle;
      logic clearing;
   } back_status_type;

   // four 2-bit fields, MSB first, taken at pass p from four row bytes
   function automatic logic [7:0] pack_fields(input logic [7:0] r0, input logic [7:0] r1,
                                              input logic [7:0] r2, input logic [7:0] r3,
                                              input logic [1:0] p);
      logic [2:0] sh;
      logic [7:0] t0, t1, t2, t3;
      sh = 3'd6 - {p, 1'b0};
      t0 = r0 >> sh;
      t1 = r1 >> sh;
      t2 = r2 >> sh;
      t3 = r3 >> sh;
      return {t0[1:0], t1[1:0], t2[1:0], t3[1:0]};
   endfunction

endpackage

// ----- hdl/mfbr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfbr_front
// Accepts request beats, decodes the kind and queues commands for the back end; beats of unknown kind are dropped.
// ----------------------------------------------------------------------------
module mfbr_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  mfbr_pkg::req_type         req_data,
   input  mfbr_pkg::back_status_type status,
   output mfbr_pkg::queue_out_type   queue_out
);

   mfbr_pkg::cmd_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       known;
   logic       push;
   mfbr_pkg::op_type op;

   always_comb begin
      known = 1'b1;
      unique case (req_data.kind)
         mfbr_pkg::KIND_PIXEL:  op = mfbr_pkg::OP_PIXEL;
         mfbr_pkg::KIND_REGION: op = mfbr_pkg::OP_REGION;
         mfbr_pkg::KIND_DATA:   op = mfbr_pkg::OP_DATA;
         mfbr_pkg::KIND_FLUSH:  op = mfbr_pkg::OP_FLUSH;
         mfbr_pkg::KIND_CLEAR:  op = mfbr_pkg::OP_CLEAR;
         default: begin
            op    = mfbr_pkg::OP_PIXEL;
            known = 1'b0;
         end
      endcase
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall && known;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ status.pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, status.pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{op: op, req: req_data};
      end
   end

   assign queue_out.valid = (count_ff != 2'd0);
   assign queue_out.cmd   = entry_ff[rd_ptr_ff];

endmodule

// ----- hdl/mfbr_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfbr_back
// Executes queued commands against the frame store and emits flush bytes.
// ----------------------------------------------------------------------------
module mfbr_back (
   input  logic                      clock,
   input  logic                      reset,
   input  mfbr_pkg::queue_out_type   queue_out,
   output mfbr_pkg::back_status_type status,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [7:0]                csr_index,
   input  logic [7:0]                csr_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output mfbr_pkg::rsp_type         rsp_data
);

   localparam int AW = mfbr_pkg::ADDR_W;
   localparam int MW = mfbr_pkg::MEM_W;
   localparam logic [AW-1:0] STORE_LIMIT = AW'(mfbr_pkg::STORE_BYTES);
   localparam logic [MW-1:0] CLEAR_LAST  = MW'(mfbr_pkg::STORE_BYTES - 1);
   localparam logic [3:0]    ROWS_LAST   = 4'(mfbr_pkg::ROWS_PER_BAND);
   localparam logic [5:0]    ROW_MAX     = 6'(mfbr_pkg::MAX_ROW_BYTES);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PIX_RD,
      ST_PIX_WR,
      ST_FL_RD,
      ST_FL_OUT
   } state_type;

   state_type state_ff;

   logic [7:0] store [mfbr_pkg::STORE_BYTES];
   logic [7:0] mem_q;
   logic          mem_we;
   logic [AW-1:0] mem_addr;
   logic [7:0]    mem_wd;

   logic [5:0]  row_bytes_ff;
   logic [3:0]  band_count_ff;
   logic [4:0]  origin_ff;
   logic [5:0]  offset_ff;
   logic [5:0]  width_ff;
   logic [7:0]  cur_row_ff;
   logic [7:0]  rows_left_ff;
   logic [12:0] bytes_left_ff;
   logic [3:0]  band_ff;
   logic [4:0]  column_ff;

   logic [MW-1:0] clr_ff;
   logic [AW-1:0] addr_ff;
   logic          rng_ff;
   logic [2:0]    bit_ff;
   logic          pix_on_ff;
   logic [3:0]    rd_cnt_ff;
   logic [7:0]    rows_ff [mfbr_pkg::ROWS_PER_BAND];
   logic [1:0]    pass_ff;
   logic [1:0]    grp_ff;
   logic          last_frame_ff;
   logic          rsp_valid_ff;
   mfbr_pkg::rsp_type rsp_ff;

   mfbr_pkg::cmd_type cmd;
   logic          pop;
   logic          region_ok;
   logic [AW-1:0] data_addr;
   logic [AW-1:0] pix_addr;
   logic [AW-1:0] flush_base;
   logic [7:0]    pix_mask;
   logic [7:0]    pix_value;
   logic [7:0]    flush_byte;
   logic          load_rsp;
   logic [5:0]    csr_row_in;
   logic [3:0]    csr_band_in;
   logic [6:0]    offset_in;
   logic [5:0]    column_in;
   logic [4:0]    band_in;

   assign cmd = queue_out.cmd;
   assign pop = (state_ff == ST_IDLE) && queue_out.valid;
   assign status.pop      = pop;
   assign status.idle     = (state_ff == ST_IDLE);
   assign status.clearing = (state_ff == ST_CLEAR);
   assign csr_ready = 1'b1;

   always_comb begin
      region_ok  = (rows_left_ff != 8'd0) && (width_ff != 6'd0) && (bytes_left_ff != 13'd0);
      data_addr  = AW'(cur_row_ff) * AW'(row_bytes_ff) + AW'(origin_ff) + AW'(offset_ff);
      pix_addr   = AW'(cmd.req.row) * AW'(row_bytes_ff) + AW'(cmd.req.pixel_x[7:3]);
      flush_base = (AW'({band_ff, 3'b000}) + AW'({band_ff, 2'b00})) * AW'(row_bytes_ff)
                   + AW'(column_ff);
      pix_mask   = 8'h80 >> bit_ff;
      pix_value  = pix_on_ff ? (mem_q | pix_mask) : (mem_q & ~pix_mask);
      offset_in  = {1'b0, offset_ff} + 7'd1;
      column_in  = {1'b0, column_ff} + 6'd1;
      band_in    = {1'b0, band_ff} + 5'd1;
      load_rsp   = (state_ff == ST_FL_OUT) && (!rsp_valid_ff || !rsp_stall);

      csr_row_in = csr_data[5:0];
      if (csr_row_in == 6'd0) begin
         csr_row_in = 6'd1;
      end else if (csr_row_in > ROW_MAX) begin
         csr_row_in = ROW_MAX;
      end
      csr_band_in = (csr_data[3:0] == 4'd0) ? 4'd1 : csr_data[3:0];

      case (grp_ff)
         2'd0: flush_byte = mfbr_pkg::pack_fields(rows_ff[0], rows_ff[1], rows_ff[2],
                                                  rows_ff[3], pass_ff);
         2'd1: flush_byte = mfbr_pkg::pack_fields(rows_ff[4], rows_ff[5], rows_ff[6],
                                                  rows_ff[7], pass_ff);
         default: flush_byte = mfbr_pkg::pack_fields(rows_ff[8], rows_ff[9], rows_ff[10],
                                                     rows_ff[11], pass_ff);
      endcase
   end

   always_comb begin
      mem_we   = 1'b0;
      mem_addr = addr_ff;
      mem_wd   = 8'd0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = AW'(clr_ff);
         end
         ST_IDLE: begin
            mem_addr = data_addr;
            mem_wd   = cmd.req.data_byte;
            mem_we   = pop && (cmd.op == mfbr_pkg::OP_DATA) && region_ok &&
                       (data_addr < STORE_LIMIT);
         end
         ST_PIX_WR: begin
            mem_we = rng_ff;
            mem_wd = pix_value;
         end
         ST_PIX_RD, ST_FL_RD, ST_FL_OUT: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[mem_addr[MW-1:0]] <= mem_wd;
      end else begin
         mem_q <= store[mem_addr[MW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         row_bytes_ff  <= mfbr_pkg::ROW_BYTES_RESET;
         band_count_ff <= mfbr_pkg::BAND_COUNT_RESET;
         origin_ff     <= 5'd0;
         offset_ff     <= 6'd0;
         width_ff      <= 6'd0;
         cur_row_ff    <= 8'd0;
         rows_left_ff  <= 8'd0;
         bytes_left_ff <= 13'd0;
         band_ff       <= 4'd0;
         column_ff     <= 5'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && !load_rsp) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            if (csr_index == mfbr_pkg::CSR_ROW_BYTES) begin
               row_bytes_ff <= csr_row_in;
               band_ff      <= 4'd0;
               column_ff    <= 5'd0;
            end else if (csr_index == mfbr_pkg::CSR_BAND_COUNT) begin
               band_count_ff <= csr_band_in;
               band_ff       <= 4'd0;
               column_ff     <= 5'd0;
            end
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == CLEAR_LAST) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (pop) begin
                  unique case (cmd.op)
                     mfbr_pkg::OP_PIXEL: begin
                        addr_ff   <= pix_addr;
                        rng_ff    <= pix_addr < STORE_LIMIT;
                        bit_ff    <= cmd.req.pixel_x[2:0];
                        pix_on_ff <= cmd.req.pixel_on;
                        state_ff  <= ST_PIX_RD;
                     end
                     mfbr_pkg::OP_REGION: begin
                        origin_ff     <= cmd.req.start_byte;
                        offset_ff     <= 6'd0;
                        width_ff      <= cmd.req.region_width_px[8:3];
                        cur_row_ff    <= cmd.req.row;
                        rows_left_ff  <= cmd.req.region_height;
                        bytes_left_ff <= cmd.req.byte_limit;
                     end
                     mfbr_pkg::OP_DATA: begin
                        if (region_ok) begin
                           bytes_left_ff <= bytes_left_ff - 13'd1;
                           if (offset_in >= {1'b0, width_ff}) begin
                              offset_ff    <= 6'd0;
                              cur_row_ff   <= cur_row_ff + 8'd1;
                              rows_left_ff <= rows_left_ff - 8'd1;
                           end else begin
                              offset_ff <= offset_in[5:0];
                           end
                        end
                     end
                     mfbr_pkg::OP_FLUSH: begin
                        addr_ff       <= flush_base;
                        rd_cnt_ff     <= 4'd0;
                        last_frame_ff <= (band_in == {1'b0, band_count_ff}) &&
                                         (column_in == row_bytes_ff);
                        if (column_in >= row_bytes_ff) begin
                           column_ff <= 5'd0;
                           band_ff   <= (band_in >= {1'b0, band_count_ff}) ? 4'd0
                                                                           : band_in[3:0];
                        end else begin
                           column_ff <= column_in[4:0];
                        end
                        state_ff <= ST_FL_RD;
                     end
                     mfbr_pkg::OP_CLEAR: begin
                        clr_ff   <= '0;
                        state_ff <= ST_CLEAR;
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            ST_PIX_RD: begin
               state_ff <= ST_PIX_WR;
            end
            ST_PIX_WR: begin
               state_ff <= ST_IDLE;
            end
            ST_FL_RD: begin
               if (rd_cnt_ff != ROWS_LAST) begin
                  addr_ff <= addr_ff + AW'(row_bytes_ff);
                  rng_ff  <= addr_ff < STORE_LIMIT;
               end
               if (rd_cnt_ff != 4'd0) begin
                  rows_ff[rd_cnt_ff - 4'd1] <= rng_ff ? mem_q : 8'd0;
               end
               rd_cnt_ff <= rd_cnt_ff + 4'd1;
               if (rd_cnt_ff == ROWS_LAST) begin
                  pass_ff  <= 2'd0;
                  grp_ff   <= 2'd0;
                  state_ff <= ST_FL_OUT;
               end
            end
            ST_FL_OUT: begin
               if (load_rsp) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_ff.out_byte   <= flush_byte;
                  rsp_ff.group_last <= (pass_ff == 2'd3) && (grp_ff == 2'd2);
                  rsp_ff.frame_last <= (pass_ff == 2'd3) && (grp_ff == 2'd2) && last_frame_ff;
                  if (grp_ff == 2'd2) begin
                     grp_ff  <= 2'd0;
                     pass_ff <= pass_ff + 2'd1;
                     if (pass_ff == 2'd3) begin
                        state_ff <= ST_IDLE;
                     end
                  end else begin
                     grp_ff <= grp_ff + 2'd1;
                  end
               end
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hdl/mono_framebuffer_band_reformatter_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_framebuffer_band_reformatter_unit
// 1-bit-per-pixel frame store with a twelve-row band reformatter.
//
// Request beats (req_valid / req_stall) carry pixel writes, region opens,
// region data bytes, flush requests and store clears. They enter a two-entry
// command queue, so the sender keeps going while the execution side works.
// Pixel writes read, modify and write a byte of the single-port store;
// region opens and data bytes execute in the idle state. A flush reads
// twelve rows, one per cycle through the store port, then emits twelve
// rsp beats. The output register holds a beat while rsp_stall is high and
// the flush sequencer waits behind it; the command queue then fills and
// raises req_stall.
// A clear, and reset, sweep all 4224 store bytes, one byte a cycle, during
// which no command executes. Reset also loads row_bytes 32, band_count 11
// and zeroes the region and flush cursors. csr writes (csr_valid / csr_ready)
// are taken at any time and must be issued only while the block is idle.
// ----------------------------------------------------------------------------
module mono_framebuffer_band_reformatter_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mfbr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mfbr_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_index,
   input  logic [7:0]        csr_data
);

   mfbr_pkg::queue_out_type   queue_out;
   mfbr_pkg::back_status_type status;

   mfbr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .status    (status),
      .queue_out (queue_out)
   );

   mfbr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .queue_out (queue_out),
      .status    (status),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      status.pop |-> (queue_out.valid && status.idle))
      else $error("command popped from empty queue or busy back end");

   a_no_rsp_while_clearing: assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> !(rsp_valid && !$past(rsp_valid)))
      else $error("response raised during store clear");

   a_frame_last_is_group_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.frame_last) |-> rsp_data.group_last)
      else $error("frame_last without group_last");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mono framebuffer band reformatter. A directed
// table (store extremes, region corner cases, unused kinds, clear) is followed
// by random traffic over several register settings and idle/stall mixes.
// Every flush beat is compared with a behavioral frame store kept here.
// ----------------------------------------------------------------------------
module tb_top;

   localparam logic [2:0] KIND_FIRST_UNUSED = 3'd5;
   localparam logic [2:0] KIND_LAST_UNUSED  = 3'd7;
   localparam logic [7:0] CSR_UNUSED        = 8'd2;
   localparam int SETTLE_CYCLES = 15000;
   localparam int BYTES_PER_FLUSH = 12;

   typedef struct {
      mfbr_pkg::req_type req;
      bit                known;
      logic [7:0]        known_byte;
   } dir_row_type;

   logic    clock, reset;
   logic    req_valid, req_stall;
   mfbr_pkg::req_type req_data;
   logic    rsp_valid, rsp_stall;
   mfbr_pkg::rsp_type rsp_data;
   logic    csr_valid, csr_ready;
   logic [7:0] csr_index, csr_data;

   mono_framebuffer_band_reformatter_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // behavioral frame store and cursors
   logic [7:0]  pix_store [mfbr_pkg::STORE_BYTES];
   int unsigned row_bytes, band_count;
   int unsigned rgn_col, rgn_off, rgn_wbytes, rgn_row, rgn_rows_left, rgn_bytes_left;
   int unsigned flush_band, flush_col;
   mfbr_pkg::rsp_type panel_q[$];

   int failures;
   int idle_mode;   // 0 none, 1 sender, 2 receiver, 3 both
   dir_row_type dir_tab[$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic void store_put(int unsigned addr, logic [7:0] v);
      if (addr < mfbr_pkg::STORE_BYTES) pix_store[addr] = v;
   endfunction

   function automatic logic [7:0] store_get(int unsigned addr);
      return (addr < mfbr_pkg::STORE_BYTES) ? pix_store[addr] : 8'h00;
   endfunction

   function automatic void apply_csr(logic [7:0] idx, logic [7:0] val);
      int unsigned v;
      if (idx == mfbr_pkg::CSR_ROW_BYTES) begin
         v = val & 8'h3F;
         if (v == 0) v = 1;
         if (v > mfbr_pkg::MAX_ROW_BYTES) v = mfbr_pkg::MAX_ROW_BYTES;
         row_bytes = v;
      end else if (idx == mfbr_pkg::CSR_BAND_COUNT) begin
         v = val & 8'h0F;
         if (v == 0) v = 1;
         band_count = v;
      end else begin
         return;
      end
      flush_band = 0;
      flush_col  = 0;
   endfunction

   // updates the frame store model; a flush pushes twelve panel beats
   function automatic void model_frame(mfbr_pkg::req_type r);
      int unsigned addr, base;
      logic [7:0]  cur, ob;
      logic [7:0]  rows [BYTES_PER_FLUSH];
      logic [7:0]  sh;
      bit          last_frame;
      mfbr_pkg::rsp_type beat;
      case (r.kind)
         mfbr_pkg::KIND_PIXEL: begin
            addr = r.row * row_bytes + (r.pixel_x >> 3);
            cur = store_get(addr);
            if (r.pixel_on) cur = cur | (8'h80 >> r.pixel_x[2:0]);
            else cur = cur & ~(8'h80 >> r.pixel_x[2:0]);
            store_put(addr, cur);
         end
         mfbr_pkg::KIND_REGION: begin
            rgn_col        = r.start_byte;
            rgn_off        = 0;
            rgn_wbytes     = r.region_width_px >> 3;
            rgn_row        = r.row;
            rgn_rows_left  = r.region_height;
            rgn_bytes_left = r.byte_limit;
         end
         mfbr_pkg::KIND_DATA: begin
            if (rgn_rows_left != 0 && rgn_wbytes != 0 && rgn_bytes_left != 0) begin
               store_put(rgn_row * row_bytes + rgn_col + rgn_off, r.data_byte);
               rgn_bytes_left--;
               rgn_off++;
               if (rgn_off >= rgn_wbytes) begin
                  rgn_off = 0;
                  rgn_row = (rgn_row + 1) & 8'hFF;
                  rgn_rows_left--;
               end
            end
         end
         mfbr_pkg::KIND_FLUSH: begin
            base = flush_band * BYTES_PER_FLUSH * row_bytes + flush_col;
            last_frame = (flush_band + 1 == band_count) && (flush_col + 1 == row_bytes);
            for (int i = 0; i < BYTES_PER_FLUSH; i++) rows[i] = store_get(base + i * row_bytes);
            for (int k = 0; k < BYTES_PER_FLUSH; k++) begin
               sh = 8'(6 - 2 * (k / 3));
               for (int j = 0; j < 4; j++) begin
                  cur = rows[4 * (k % 3) + j] >> sh;
                  ob[7 - 2 * j -: 2] = cur[1:0];
               end
               beat.out_byte   = ob;
               beat.group_last = (k == BYTES_PER_FLUSH - 1);
               beat.frame_last = (k == BYTES_PER_FLUSH - 1) && last_frame;
               panel_q.push_back(beat);
            end
            flush_col++;
            if (flush_col >= row_bytes) begin
               flush_col = 0;
               flush_band++;
               if (flush_band >= band_count) flush_band = 0;
            end
         end
         mfbr_pkg::KIND_CLEAR: begin
            foreach (pix_store[i]) pix_store[i] = 8'h00;
         end
         default: ;
      endcase
   endfunction

   function automatic bit draw_sender_idle();
      return (idle_mode == 1) ? ($urandom_range(0, 99) < 70) :
             (idle_mode == 3) ? ($urandom_range(0, 99) < 35) : 1'b0;
   endfunction

   task automatic send_beat(input mfbr_pkg::req_type r);
      @(negedge clock);
      while (draw_sender_idle()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      model_frame(r);
   endtask

   task automatic write_csr(input logic [7:0] idx, input logic [7:0] val);
      @(negedge clock);
      req_valid <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait out all panel beats, then any clears or pixel writes still in flight
   task automatic drain_and_settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (panel_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic mfbr_pkg::req_type mkreq(logic [2:0] kind, logic [7:0] x,
                                               logic [7:0] row, logic on, logic [4:0] sb,
                                               logic [8:0] wpx, logic [7:0] h,
                                               logic [12:0] lim, logic [7:0] d);
      mfbr_pkg::req_type r;
      r.kind = kind; r.pixel_x = x; r.row = row; r.pixel_on = on; r.start_byte = sb;
      r.region_width_px = wpx; r.region_height = h; r.byte_limit = lim; r.data_byte = d;
      return r;
   endfunction

   function automatic mfbr_pkg::req_type rand_req();
      mfbr_pkg::req_type r;
      int unsigned pick;
      r = mfbr_pkg::req_type'({$urandom, $urandom});
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         r.kind = mfbr_pkg::KIND_PIXEL;
         if ($urandom_range(0, 3) != 0) begin
            r.pixel_x = 8'($urandom_range(0, 8 * row_bytes - 1));
            r.row = 8'($urandom_range(0, 35));
         end
      end else if (pick < 15) begin
         r.kind = mfbr_pkg::KIND_REGION;
         r.row = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 30));
         r.start_byte = 5'($urandom_range(0, row_bytes - 1));
         r.region_width_px = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(0, 256)) :
                                                           9'($urandom_range(0, 40));
         r.region_height = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) :
                                                         8'($urandom_range(0, 5));
         r.byte_limit = ($urandom_range(0, 1) == 0) ? 13'd4224 :
                                                      13'($urandom_range(0, 4224));
      end else if (pick < 50) begin
         r.kind = mfbr_pkg::KIND_DATA;
      end else if (pick < 86) begin
         r.kind = mfbr_pkg::KIND_FLUSH;
      end else if (pick < 88) begin
         r.kind = mfbr_pkg::KIND_CLEAR;
      end else if (pick < 94) begin
         r.kind = 3'($urandom_range(KIND_FIRST_UNUSED, KIND_LAST_UNUSED));
      end else begin
         r.kind = 3'($urandom_range(mfbr_pkg::KIND_PIXEL, mfbr_pkg::KIND_FLUSH));
      end
      return r;
   endfunction

   // receiver side
   always @(negedge clock) begin
      if (idle_mode == 2) rsp_stall <= ($urandom_range(0, 99) < 70);
      else if (idle_mode == 3) rsp_stall <= ($urandom_range(0, 99) < 35);
      else rsp_stall <= 1'b0;
   end

   always @(posedge clock) begin
      mfbr_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (panel_q.size() == 0) begin
            $display("%0t unexpected beat: got byte %02h gl %b fl %b", $time,
                     rsp_data.out_byte, rsp_data.group_last, rsp_data.frame_last);
            failures++;
         end else begin
            want = panel_q.pop_front();
            if (rsp_data.out_byte !== want.out_byte) begin
               $display("%0t out_byte: expected %02h got %02h", $time, want.out_byte,
                        rsp_data.out_byte);
               failures++;
            end
            if (rsp_data.group_last !== want.group_last) begin
               $display("%0t group_last: expected %b got %b", $time, want.group_last,
                        rsp_data.group_last);
               failures++;
            end
            if (rsp_data.frame_last !== want.frame_last) begin
               $display("%0t frame_last: expected %b got %b", $time, want.frame_last,
                        rsp_data.frame_last);
               failures++;
            end
         end
      end
   end

   initial begin
      dir_row_type dr;
      int          n0;
      req_valid = 1'b0; req_data = '0; rsp_stall = 1'b0;
      csr_valid = 1'b0; csr_index = '0; csr_data = '0;
      failures = 0; idle_mode = 0;
      foreach (pix_store[i]) pix_store[i] = 8'h00;
      row_bytes = mfbr_pkg::ROW_BYTES_RESET; band_count = mfbr_pkg::BAND_COUNT_RESET;
      rgn_col = 0; rgn_off = 0; rgn_wbytes = 0; rgn_row = 0;
      rgn_rows_left = 0; rgn_bytes_left = 0; flush_band = 0; flush_col = 0;

      reset = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table; known rows carry a typed panel byte
      dir_tab = '{
         '{mkreq(mfbr_pkg::KIND_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0), 1, 8'h00},
         '{mkreq(mfbr_pkg::KIND_PIXEL, 8'd0, 8'd0, 1, 0, 0, 0, 0, 0), 0, 0},
         '{mkreq(mfbr_pkg::KIND_PIXEL, 8'd255, 8'd131, 1, 0, 0, 0, 0, 0), 0, 0},
         '{mkreq(mfbr_pkg::KIND_PIXEL, 8'd255, 8'd255, 1, 0, 0, 0, 0, 0), 0, 0},
         '{mkreq(mfbr_pkg::KIND_PIXEL, 8'd9, 8'd11, 1, 0, 0, 0, 0, 0), 0, 0},
         '{mkreq(mfbr_pkg::KIND_PIXEL, 8'd0, 8'd0, 0, 0, 0, 0, 0, 0), 0, 0},
         '{mkreq(mfbr_pkg::KIND_REGION, 0, 8'd0, 0, 5'd1, 9'd16, 8'd12, 13'd4224, 0), 0, 0},
         '{mkreq(mfbr_pkg::KIND_DATA, 0, 0, 0, 0, 0, 0, 0, 8'hFF), 0, 0},
         '{mkreq(mfbr_pkg::KIND_DATA, 0, 0, 0, 0, 0, 0, 0, 8'h00), 0, 0},
         '{mkreq(mfbr_pkg::KIND_DATA, 0, 0, 0, 0, 0, 0, 0, 8'hA5), 0, 0},
         '{mkreq(mfbr_pkg::KIND_DATA, 0, 0, 0, 0, 0, 0, 0, 8'h3C), 0, 0},
         '{mkreq(mfbr_pkg::KIND_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0},
         '{mkreq(mfbr_pkg::KIND_REGION, 0, 8'd255, 0, 5'd31, 9'd256, 8'd255, 13'd2, 0), 0, 0},
         '{mkreq(mfbr_pkg::KIND_DATA, 0, 0, 0, 0, 0, 0, 0, 8'h81), 0, 0},
         '{mkreq(mfbr_pkg::KIND_DATA, 0, 0, 0, 0, 0, 0, 0, 8'h18), 0, 0},
         '{mkreq(mfbr_pkg::KIND_DATA, 0, 0, 0, 0, 0, 0, 0, 8'h77), 0, 0},
         '{mkreq(mfbr_pkg::KIND_REGION, 0, 8'd2, 0, 5'd31, 9'd7, 8'd3, 13'd10, 0), 0, 0},
         '{mkreq(mfbr_pkg::KIND_DATA, 0, 0, 0, 0, 0, 0, 0, 8'h55), 0, 0},
         '{mkreq(mfbr_pkg::KIND_REGION, 0, 8'd3, 0, 5'd31, 9'd24, 8'd2, 13'd0, 0), 0, 0},
         '{mkreq(mfbr_pkg::KIND_DATA, 0, 0, 0, 0, 0, 0, 0, 8'h66), 0, 0},
         '{mkreq(KIND_FIRST_UNUSED, 8'hFF, 8'hFF, 1, 5'h1F, 9'h1FF, 8'hFF, 13'h1FFF, 8'hFF),
           0, 0},
         '{mkreq(KIND_LAST_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0},
         '{mkreq(mfbr_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0},
         '{mkreq(mfbr_pkg::KIND_FLUSH, 0, 0, 0, 0, 0, 0, 0, 0), 1, 8'h00}
      };
      foreach (dir_tab[i]) begin
         dr = dir_tab[i];
         n0 = panel_q.size();
         send_beat(dr.req);
         if (dr.known)
            for (int k = n0; k < panel_q.size(); k++) panel_q[k].out_byte = dr.known_byte;
      end

      for (int ph = 0; ph < 5; ph++) begin
         drain_and_settle();
         case (ph)
            0: begin
               write_csr(mfbr_pkg::CSR_ROW_BYTES, 8'd1);
               write_csr(mfbr_pkg::CSR_BAND_COUNT, 8'd1);
            end
            1: begin
               write_csr(mfbr_pkg::CSR_ROW_BYTES, 8'd0);
               write_csr(mfbr_pkg::CSR_BAND_COUNT, 8'd0);
               write_csr(CSR_UNUSED, 8'hFF);
            end
            2: begin
               write_csr(mfbr_pkg::CSR_ROW_BYTES, 8'd3);
               write_csr(mfbr_pkg::CSR_BAND_COUNT, 8'd2);
            end
            3: begin
               write_csr(mfbr_pkg::CSR_ROW_BYTES, 8'hFF);
               write_csr(mfbr_pkg::CSR_BAND_COUNT, 8'd15);
            end
            default: begin
               write_csr(mfbr_pkg::CSR_ROW_BYTES, 8'd2);
               write_csr(mfbr_pkg::CSR_BAND_COUNT, 8'd11);
            end
         endcase
         idle_mode = (ph == 4) ? 0 : ph;
         for (int i = 0; i < 54; i++) begin
            if (ph == 3 && i == 27) begin
               idle_mode = 3;
               @(negedge clock);
               req_valid <= 1'b0;
               while (panel_q.size() != 0) @(posedge clock);
            end
            send_beat(rand_req());
         end
      end

      idle_mode = 0;
      drain_and_settle();
      if (failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
